### src/ogru_pkg.sv
// Package for the occupancy grid ray update block.
// Holds the default sizes, register codes, reset values, sequencer states and CORDIC table.
// No dependencies.
package ogru_pkg;

  localparam int MAP_WIDTH_DEF  = 256;
  localparam int MAP_HEIGHT_DEF = 256;
  localparam int PROB_BITS_DEF  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RANGE_THR = 3'd0,
    REG_CELL_SIZE = 3'd1,
    REG_PRIOR     = 3'd2,
    REG_HIT_RATE  = 3'd3,
    REG_MISS_RATE = 3'd4,
    REG_DECAY     = 3'd5
  } cfg_reg_t;

  typedef enum logic {
    CMD_BEAM = 1'b0,
    CMD_READ = 1'b1
  } cmd_t;

  localparam logic [15:0] RANGE_THR_RST = 16'd8000;
  localparam logic [15:0] CELL_SIZE_RST = 16'd50;
  localparam logic [15:0] PRIOR_RST     = 16'd32768;
  localparam logic [15:0] HIT_RATE_RST  = 16'd58982;
  localparam logic [15:0] MISS_RATE_RST = 16'd31457;
  localparam logic [15:0] DECAY_RST     = 16'd62259;

  // CORDIC: 15 rotations, Q4.30 start vector carries the inverse gain
  localparam int CORDIC_STEPS = 15;
  localparam int CORDIC_W     = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COR,
    ST_MULX,
    ST_DVXI,
    ST_DVX,
    ST_MULY,
    ST_DVYI,
    ST_DVY,
    ST_END,
    ST_INIT,
    ST_RD,
    ST_MA,
    ST_MB,
    ST_MN,
    ST_MD,
    ST_BDI,
    ST_BDV,
    ST_WR,
    ST_STEP,
    ST_FRD,
    ST_DONE
  } ogru_state_t;

  // arctangent of 2^-i in units of 1/65536 turn
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      4'd14:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

### src/ogru_if.sv
// Channel interfaces of the occupancy grid ray update block: beam/read input,
// result output and register write port. No dependencies.
interface ogru_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [7:0]  pos_x;
  logic [7:0]  pos_y;
  logic [15:0] heading;
  logic [15:0] beam_range;
  logic [15:0] beam_angle;
  logic [7:0]  read_x;
  logic [7:0]  read_y;

  modport source (output valid, cmd, pos_x, pos_y, heading, beam_range, beam_angle,
                  read_x, read_y, input ready);
  modport sink (input valid, cmd, pos_x, pos_y, heading, beam_range, beam_angle,
                read_x, read_y, output ready);
endinterface

interface ogru_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  hit_x;
  logic [7:0]  hit_y;
  logic [15:0] cell_prob;
  logic        cell_visited;
  logic [7:0]  bound_left;
  logic [7:0]  bound_right;
  logic [7:0]  bound_low;
  logic [7:0]  bound_high;

  modport source (output valid, hit_x, hit_y, cell_prob, cell_visited, bound_left,
                  bound_right, bound_low, bound_high, input ready);
  modport sink (input valid, hit_x, hit_y, cell_prob, cell_visited, bound_left,
                bound_right, bound_low, bound_high, output ready);
endinterface

interface ogru_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/occupancy_grid_ray_update.sv
// Occupancy grid ray update: top level, sequencer, shared multiplier, shared divider,
// CORDIC rotator and grid memory. Depends on ogru_pkg and the channel interfaces in ogru_if.
//
// After reset the block runs a clearing pass over all MAP_WIDTH*MAP_HEIGHT cells (65536 at the
// default size) that sets every cell to the reset prior and clears the visited marks; no
// transaction is taken on the input channel meanwhile, register writes are. The block works
// on one item at a time and takes the next once the result sits in the output register. A
// beam item does the CORDIC rotation and the two cell-size divisions, then updates each cell
// on the ray, with the shared multiplier doing five products per cell and the bit-serial
// divider giving one quotient bit per cycle; a ray has max(|dx|,|dy|)+1 cells, up to 256 on
// the default map.
module occupancy_grid_ray_update
  import ogru_pkg::*;
#(
  parameter int MAP_WIDTH  = MAP_WIDTH_DEF,
  parameter int MAP_HEIGHT = MAP_HEIGHT_DEF,
  parameter int PROB_BITS  = PROB_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ogru_in_if.sink    in_ch,
  ogru_out_if.source out_ch,
  ogru_cfg_if.sink   cfg_ch
);

  localparam int P      = PROB_BITS;
  localparam int XW     = $clog2(MAP_WIDTH);
  localparam int YW     = $clog2(MAP_HEIGHT);
  localparam int DEPTH  = MAP_WIDTH * MAP_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int SH     = (4 * P > 64) ? (4 * P - 64) : 0;
  localparam int UPSH   = (P >= 16) ? (P - 16) : 0;
  localparam int DNSH   = (P >= 16) ? 0 : (16 - P);
  localparam int AW     = 2 * P - SH;
  localparam int NW     = AW + P;
  localparam int MA     = (AW + 1 > CORDIC_W) ? AW + 1 : CORDIC_W;
  localparam int MB     = (P + 2 > 17) ? P + 2 : 17;
  localparam int MPW    = MA + MB;
  localparam int DW     = (NW + 1 > 16) ? NW + 1 : 16;
  localparam int DSW    = 17;
  localparam int QW     = (P + 1 > DSW) ? P + 1 : DSW;
  localparam int CW     = (XW > YW) ? XW : YW;
  localparam int EW     = CW + 3;
  localparam logic [P:0] SCALE = (P + 1)'(1) << P;

  // configuration registers
  logic [15:0] range_thr_r, cell_size_r, prior_r, hit_rate_r, miss_rate_r, decay_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_thr_r <= RANGE_THR_RST;
      cell_size_r <= CELL_SIZE_RST;
      prior_r     <= PRIOR_RST;
      hit_rate_r  <= HIT_RATE_RST;
      miss_rate_r <= MISS_RATE_RST;
      decay_r     <= DECAY_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_RANGE_THR: range_thr_r <= cfg_ch.data;
        REG_CELL_SIZE: cell_size_r <= cfg_ch.data;
        REG_PRIOR:     prior_r     <= cfg_ch.data;
        REG_HIT_RATE:  hit_rate_r  <= cfg_ch.data;
        REG_MISS_RATE: miss_rate_r <= cfg_ch.data;
        REG_DECAY:     decay_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  function automatic logic [P-1:0] to_prob(input logic [15:0] v);
    logic [P+15:0] w;
    w = (P + 16)'(v);
    return P'((w << UPSH) >> DNSH);
  endfunction

  function automatic logic [15:0] from_prob(input logic [P-1:0] v);
    logic [P+15:0] w;
    w = (P + 16)'(v);
    return 16'((w >> UPSH) << DNSH);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [XW-1:0] x,
                                                  input logic [YW-1:0] y);
    return ADDR_W'(ADDR_W'(y) * ADDR_W'(MAP_WIDTH) + ADDR_W'(x));
  endfunction

  // state and datapath registers
  ogru_state_t state_r, state_nxt;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [XW-1:0] px_r, hx_r, bx_r, min_x_r, max_x_r;
  logic [YW-1:0] py_r, hy_r, by_r, min_y_r, max_y_r;
  logic [7:0]    rdx_r, rdy_r;
  logic          is_read_r, offmap_r;
  logic [15:0]   rng_r;

  logic signed [CORDIC_W-1:0] cx_r, cy_r;
  logic signed [17:0]         cz_r;
  logic [3:0]                 cor_i_r;
  logic                       flip_r;

  logic signed [18:0] offx_r;
  logic               neg_r;

  logic signed [EW-1:0] dx_r, dy_r, err_r;
  logic                 sx_r, sy_r;
  logic [P-1:0]         rate_r, p_r;
  logic [AW-1:0]        a_r, b_r;
  logic [NW-1:0]        n_r;
  logic                 t0_r;

  logic [DW-1:0]  dv_rem_r, dv_den_r;
  logic [DSW-1:0] dv_dsr_r;
  logic [QW-1:0]  dv_quo_r;
  logic [4:0]     dv_cnt_r;

  logic out_valid_r;
  logic [7:0]  o_hx_r, o_hy_r, o_bl_r, o_br_r, o_blo_r, o_bhi_r;
  logic [15:0] o_prob_r;
  logic        o_vis_r;

  // grid memory: visited mark on top of the probability
  logic [P:0]        mem [DEPTH];
  logic [P:0]        rd_data_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [P:0]        mem_wdata;

  // shared multiplier
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic signed [MPW-1:0] mul_r;

  always_ff @(posedge clk) begin
    mul_r <= mul_a * mul_b;
  end

  logic [P-1:0]               pr_p;
  logic signed [CORDIC_W-1:0] cor_c, cor_s;
  assign pr_p  = to_prob(prior_r);
  assign cor_c = flip_r ? -cx_r : cx_r;
  assign cor_s = flip_r ? -cy_r : cy_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MULX: begin
        mul_a = MA'(cor_c);
        mul_b = MB'($signed({1'b0, rng_r}));
      end
      ST_MULY: begin
        mul_a = MA'(cor_s);
        mul_b = MB'($signed({1'b0, rng_r}));
      end
      ST_MA: begin
        mul_a = MA'($signed({1'b0, rate_r}));
        mul_b = MB'($signed({1'b0, SCALE - (P + 1)'(pr_p)}));
      end
      ST_MB: begin
        mul_a = MA'($signed({1'b0, SCALE - (P + 1)'(rate_r)}));
        mul_b = MB'($signed({1'b0, pr_p}));
      end
      ST_MN: begin
        mul_a = MA'($signed({1'b0, a_r}));
        mul_b = MB'($signed({1'b0, p_r}));
      end
      ST_MD: begin
        mul_a = MA'($signed({1'b0, b_r}));
        mul_b = MB'($signed({1'b0, SCALE - (P + 1)'(p_r)}));
      end
      ST_WR: begin
        mul_a = MA'($signed({1'b0, rate_r}));
        mul_b = MB'($signed({1'b0, decay_r}));
      end
      default: ;
    endcase
  end

  // shared restoring divider step, one quotient bit per cycle
  logic [DW:0]   dv_rem2;
  logic          dv_ge;
  logic [DW-1:0] dv_rem_nxt;
  assign dv_rem2    = {dv_rem_r, dv_dsr_r[DSW-1]};
  assign dv_ge      = dv_rem2 >= {1'b0, dv_den_r};
  assign dv_rem_nxt = dv_ge ? DW'(dv_rem2 - {1'b0, dv_den_r}) : dv_rem2[DW-1:0];

  // scaled beam offset: floor(c*range / 2^30), then floored division by the cell size
  logic signed [17:0] cq;
  logic [16:0]        cq_mag;
  logic [15:0]        cs_eff;
  assign cq     = 18'(mul_r >>> 30);
  assign cq_mag = cq[17] ? 17'(-cq) : 17'(cq);
  assign cs_eff = (cell_size_r == '0) ? 16'd1 : cell_size_r;

  logic signed [18:0] off_now;
  logic [17:0]        quo_up;
  assign quo_up  = 18'(dv_quo_r[16:0]) + 18'(dv_rem_r != '0);
  assign off_now = neg_r ? -$signed({1'b0, quo_up}) : $signed({2'b0, dv_quo_r[16:0]});

  logic signed [19:0] sumx, sumy;
  logic [XW-1:0]      endx;
  logic [YW-1:0]      endy;
  assign sumx = $signed(20'(px_r)) + 20'(offx_r);
  assign sumy = $signed(20'(py_r)) + 20'(off_now);
  assign endx = (sumx < 0) ? '0 :
                (sumx > $signed(20'(MAP_WIDTH - 1))) ? XW'(MAP_WIDTH - 1) : XW'(sumx);
  assign endy = (sumy < 0) ? '0 :
                (sumy > $signed(20'(MAP_HEIGHT - 1))) ? YW'(MAP_HEIGHT - 1) : YW'(sumy);

  // Bresenham setup and step
  logic signed [EW-1:0] ex, ey, e2, err_nxt;
  logic                 c_x, c_y;
  assign ex      = $signed(EW'(hx_r)) - $signed(EW'(px_r));
  assign ey      = $signed(EW'(hy_r)) - $signed(EW'(py_r));
  assign e2      = err_r <<< 1;
  assign c_x     = e2 > -dy_r;
  assign c_y     = e2 < dx_r;
  assign err_nxt = err_r - (c_x ? dy_r : '0) + (c_y ? dx_r : '0);

  // Bayes result: quotient + 1, saturated
  logic [P:0]   bq;
  logic [P+1:0] bq1;
  logic [P-1:0] new_p;
  assign bq    = t0_r ? '0 : dv_quo_r[P:0];
  assign bq1   = (P + 2)'(bq) + (P + 2)'(1);
  assign new_p = (bq1 > (P + 2)'(SCALE - 1'b1)) ? P'(SCALE - 1'b1) : P'(bq1);

  logic [NW:0] t_sum;
  assign t_sum = {1'b0, n_r} + {1'b0, NW'(mul_r)};

  // angle reduction to the right half plane
  logic [15:0]        ang;
  logic signed [15:0] ang_s;
  assign ang   = in_ch.heading + in_ch.beam_angle;
  assign ang_s = $signed(ang);

  logic signed [CORDIC_W-1:0] xs, ys;
  logic signed [17:0]         at;
  assign xs = cx_r >>> cor_i_r;
  assign ys = cy_r >>> cor_i_r;
  assign at = $signed(18'(atan_lut(cor_i_r)));

  logic in_fire;
  assign in_fire      = in_ch.valid && (state_r == ST_IDLE);
  assign in_ch.ready  = (state_r == ST_IDLE);

  // memory ports
  logic walk;
  assign walk = (state_r == ST_RD) || (state_r == ST_MA) || (state_r == ST_MB) ||
                (state_r == ST_MN) || (state_r == ST_MD) || (state_r == ST_BDI) ||
                (state_r == ST_BDV) || (state_r == ST_WR) || (state_r == ST_STEP);
  assign mem_raddr = walk ? cell_addr(bx_r, by_r) : cell_addr(hx_r, hy_r);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr(bx_r, by_r);
    mem_wdata = {1'b1, new_p};
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = {1'b0, to_prob(PRIOR_RST)};
    end else if (state_r == ST_WR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rd_data_r <= mem[mem_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = (in_ch.cmd == CMD_READ) ? ST_FRD : ST_COR;
      end
      ST_COR:  if (cor_i_r == 4'(CORDIC_STEPS - 1)) state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_DVXI;
      ST_DVXI: state_nxt = ST_DVX;
      ST_DVX:  if (dv_cnt_r == 5'd1) state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_DVYI;
      ST_DVYI: state_nxt = ST_DVY;
      ST_DVY:  if (dv_cnt_r == 5'd1) state_nxt = ST_END;
      ST_END:  state_nxt = ST_INIT;
      ST_INIT: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_MA;
      ST_MA:   state_nxt = ST_MB;
      ST_MB:   state_nxt = ST_MN;
      ST_MN:   state_nxt = ST_MD;
      ST_MD:   state_nxt = ST_BDI;
      ST_BDI:  state_nxt = ST_BDV;
      ST_BDV:  if (dv_cnt_r == 5'd1) state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_STEP;
      ST_STEP: state_nxt = (bx_r == px_r && by_r == py_r) ? ST_FRD : ST_RD;
      ST_FRD:  state_nxt = ST_DONE;
      ST_DONE: if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      min_x_r   <= XW'(MAP_WIDTH - 1);
      max_x_r   <= '0;
      min_y_r   <= YW'(MAP_HEIGHT - 1);
      max_y_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (state_r == ST_INIT) begin
        if (hx_r < min_x_r) min_x_r <= hx_r;
        if (hx_r > max_x_r) max_x_r <= hx_r;
        if (hy_r < min_y_r) min_y_r <= hy_r;
        if (hy_r > max_y_r) max_y_r <= hy_r;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          is_read_r <= (in_ch.cmd == CMD_READ);
          rdx_r     <= in_ch.read_x;
          rdy_r     <= in_ch.read_y;
          rng_r     <= in_ch.beam_range;
          if (in_ch.cmd == CMD_READ) begin
            hx_r     <= XW'(in_ch.read_x);
            hy_r     <= YW'(in_ch.read_y);
            offmap_r <= (int'(in_ch.read_x) >= MAP_WIDTH) ||
                        (int'(in_ch.read_y) >= MAP_HEIGHT);
          end else begin
            offmap_r <= 1'b0;
          end
          px_r <= (int'(in_ch.pos_x) > MAP_WIDTH - 1) ? XW'(MAP_WIDTH - 1) : XW'(in_ch.pos_x);
          py_r <= (int'(in_ch.pos_y) > MAP_HEIGHT - 1) ? YW'(MAP_HEIGHT - 1)
                                                      : YW'(in_ch.pos_y);
          cx_r    <= CORDIC_GAIN;
          cy_r    <= '0;
          cor_i_r <= '0;
          if (ang_s > 16'sd16384) begin
            cz_r   <= 18'(ang_s) - 18'sd32768;
            flip_r <= 1'b1;
          end else if (ang_s < -16'sd16384) begin
            cz_r   <= 18'(ang_s) + 18'sd32768;
            flip_r <= 1'b1;
          end else begin
            cz_r   <= 18'(ang_s);
            flip_r <= 1'b0;
          end
        end
      end
      ST_COR: begin
        cor_i_r <= cor_i_r + 1'b1;
        if (!cz_r[17]) begin
          cx_r <= cx_r - ys;
          cy_r <= cy_r + xs;
          cz_r <= cz_r - at;
        end else begin
          cx_r <= cx_r + ys;
          cy_r <= cy_r - xs;
          cz_r <= cz_r + at;
        end
      end
      ST_DVXI, ST_DVYI: begin
        neg_r    <= cq[17];
        dv_rem_r <= '0;
        dv_den_r <= DW'(cs_eff);
        dv_dsr_r <= cq_mag;
        dv_quo_r <= '0;
        dv_cnt_r <= 5'(DSW);
      end
      ST_DVX, ST_DVY, ST_BDV: begin
        dv_rem_r <= dv_rem_nxt;
        dv_dsr_r <= dv_dsr_r << 1;
        dv_quo_r <= {dv_quo_r[QW-2:0], dv_ge};
        dv_cnt_r <= dv_cnt_r - 1'b1;
      end
      ST_MULY: offx_r <= off_now;
      ST_END: begin
        hx_r <= endx;
        hy_r <= endy;
      end
      ST_INIT: begin
        dx_r   <= ex[EW-1] ? -ex : ex;
        dy_r   <= ey[EW-1] ? -ey : ey;
        err_r  <= (ex[EW-1] ? -ex : ex) - (ey[EW-1] ? -ey : ey);
        sx_r   <= hx_r < px_r;
        sy_r   <= hy_r < py_r;
        bx_r   <= hx_r;
        by_r   <= hy_r;
        rate_r <= to_prob((rng_r < range_thr_r) ? hit_rate_r : miss_rate_r);
      end
      ST_MA: p_r <= rd_data_r[P-1:0];
      ST_MB: a_r <= AW'(mul_r >> SH);
      ST_MN: b_r <= AW'(mul_r >> SH);
      ST_MD: n_r <= NW'(mul_r);
      ST_BDI: begin
        // quotient of N*2^P by N+D, starting with the bit worth 2^P
        t0_r     <= (t_sum == '0);
        dv_rem_r <= DW'(n_r >> 1);
        dv_dsr_r <= {n_r[0], {(DSW - 1){1'b0}}};
        dv_den_r <= DW'(t_sum);
        dv_quo_r <= '0;
        dv_cnt_r <= 5'(P + 1);
      end
      ST_STEP: begin
        if (rate_r > P'(SCALE >> 1)) rate_r <= to_prob(miss_rate_r);
        else                         rate_r <= P'(mul_r >> 16);
        err_r <= err_nxt;
        if (c_x) bx_r <= sx_r ? bx_r + XW'(1) : bx_r - XW'(1);
        if (c_y) by_r <= sy_r ? by_r + YW'(1) : by_r - YW'(1);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DONE && (!out_valid_r || out_ch.ready)) begin
      o_hx_r   <= is_read_r ? rdx_r : 8'(hx_r);
      o_hy_r   <= is_read_r ? rdy_r : 8'(hy_r);
      o_prob_r <= offmap_r ? 16'd0 : from_prob(rd_data_r[P-1:0]);
      o_vis_r  <= offmap_r ? 1'b0 : rd_data_r[P];
      o_bl_r   <= 8'(min_x_r);
      o_br_r   <= 8'(max_x_r);
      o_blo_r  <= 8'(min_y_r);
      o_bhi_r  <= 8'(max_y_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit_x        = o_hx_r;
  assign out_ch.hit_y        = o_hy_r;
  assign out_ch.cell_prob    = o_prob_r;
  assign out_ch.cell_visited = o_vis_r;
  assign out_ch.bound_left   = o_bl_r;
  assign out_ch.bound_right  = o_br_r;
  assign out_ch.bound_low    = o_blo_r;
  assign out_ch.bound_high   = o_bhi_r;

endmodule

### sim/tb_occupancy_grid_ray_update.sv
// Testbench for occupancy_grid_ray_update: directed and random beam/read traffic
// checked against an in-bench grid predictor. Depends on ogru_pkg and the ogru_if interfaces.
module tb_occupancy_grid_ray_update;
  import ogru_pkg::*;

  localparam int GRID_W       = 256;
  localparam int GRID_H       = 256;
  localparam int QSCALE       = 65536;
  localparam int STALL_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [2:0] REG_SPARE = 3'd6;

  typedef struct packed {
    logic [7:0]  hx;
    logic [7:0]  hy;
    logic [15:0] prob;
    logic        vis;
    logic [7:0]  b_left;
    logic [7:0]  b_right;
    logic [7:0]  b_low;
    logic [7:0]  b_high;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst_n;

  ogru_in_if  in_ch ();
  ogru_out_if out_ch ();
  ogru_cfg_if cfg_ch ();

  occupancy_grid_ray_update dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [15:0] grid_prob [GRID_W*GRID_H];
  logic        grid_seen [GRID_W*GRID_H];
  int          min_x, max_x, min_y, max_y;
  logic [15:0] regs [6];
  cell_result_t pending_results [$];

  int mismatches = 0;
  int n_beams = 0, n_reads = 0, n_results = 0;
  bit no_idle = 1'b0;
  int hold_req = 0;
  int last_hx = 0, last_hy = 0;

  localparam int ATAN_TURN [15] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20,
                                    10, 5, 3, 1, 1};

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic void rotate(input logic [15:0] ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = ang;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z >= 32768) z -= 65536;
    if (z > 16384) begin
      z -= 32768;
      flip = 1'b1;
    end else if (z < -16384) begin
      z += 32768;
      flip = 1'b1;
    end
    for (int i = 0; i < 15; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_TURN[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_TURN[i];
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint div_floor(input longint num, input longint den);
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic int clamp_cell(input longint v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return int'(v);
  endfunction

  function automatic logic [15:0] bayes_update(input longint unsigned p, m, r);
    longint unsigned a, b, n, d, q;
    a = m * (QSCALE - r);
    b = (QSCALE - m) * r;
    n = a * p;
    d = b * (QSCALE - p);
    q = (n + d) != 0 ? (n * QSCALE) / (n + d) : 0;
    q += 1;
    if (q > QSCALE - 1) q = QSCALE - 1;
    return q[15:0];
  endfunction

  function automatic cell_result_t predict_beam(input logic [7:0] px, py,
      input logic [15:0] hdg, rng, ang);
    cell_result_t res;
    longint c, s, den;
    longint unsigned rate;
    int x, y, dx, dy, sx, sy, err, e2, idx;
    rotate(hdg + ang, c, s);
    den = longint'(regs[REG_CELL_SIZE] != 0 ? regs[REG_CELL_SIZE] : 16'd1) << 30;
    x = clamp_cell(longint'(px) + div_floor(c * rng, den), GRID_W - 1);
    y = clamp_cell(longint'(py) + div_floor(s * rng, den), GRID_H - 1);
    res.hx = 8'(x);
    res.hy = 8'(y);
    if (x < min_x) min_x = x;
    if (x > max_x) max_x = x;
    if (y < min_y) min_y = y;
    if (y > max_y) max_y = y;
    rate = 64'((rng < regs[REG_RANGE_THR]) ? regs[REG_HIT_RATE] : regs[REG_MISS_RATE]);
    dx = x > px ? x - px : px - x;
    dy = y > py ? y - py : py - y;
    sx = x < px ? 1 : -1;
    sy = y < py ? 1 : -1;
    err = dx - dy;
    forever begin
      idx = y * GRID_W + x;
      grid_prob[idx] = bayes_update(grid_prob[idx], rate, regs[REG_PRIOR]);
      grid_seen[idx] = 1'b1;
      if (rate > QSCALE / 2) rate = 64'(regs[REG_MISS_RATE]);
      else rate = (rate * regs[REG_DECAY]) >> 16;
      if (x == px && y == py) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        x += sx;
      end
      if (e2 < dx) begin
        err += dx;
        y += sy;
      end
    end
    idx = res.hy * GRID_W + res.hx;
    res.prob = grid_prob[idx];
    res.vis = grid_seen[idx];
    res.b_left = 8'(min_x);
    res.b_right = 8'(max_x);
    res.b_low = 8'(min_y);
    res.b_high = 8'(max_y);
    return res;
  endfunction

  task automatic send_item(input cmd_t cmd, input logic [7:0] px, py,
      input logic [15:0] hdg, rng, ang, input logic [7:0] rx, ry);
    cell_result_t res;
    if (!no_idle && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.heading <= hdg;
    in_ch.beam_range <= rng;
    in_ch.beam_angle <= ang;
    in_ch.read_x <= rx;
    in_ch.read_y <= ry;
    do @(posedge clk); while (!in_ch.ready);
    if (cmd == CMD_READ) begin
      res.hx = rx;
      res.hy = ry;
      res.prob = grid_prob[ry * GRID_W + rx];
      res.vis = grid_seen[ry * GRID_W + rx];
      res.b_left = 8'(min_x);
      res.b_right = 8'(max_x);
      res.b_low = 8'(min_y);
      res.b_high = 8'(max_y);
      n_reads++;
    end else begin
      res = predict_beam(px, py, hdg, rng, ang);
      last_hx = res.hx;
      last_hy = res.hy;
      n_beams++;
    end
    pending_results.push_back(res);
  endtask

  task automatic send_beam(input logic [7:0] px, py, input logic [15:0] hdg, rng, ang);
    send_item(CMD_BEAM, px, py, hdg, rng, ang, 8'($urandom), 8'($urandom));
  endtask

  task automatic send_read(input logic [7:0] rx, ry);
    send_item(CMD_READ, 8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
              16'($urandom), rx, ry);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx <= REG_DECAY) regs[idx] = val;
    @(posedge clk);
  endtask

  // receiver side: random stalls, a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != 0) begin
        hold_left = HOLD_CYCLES;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(99) >= 21);
      end
    end
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_results++;
      if (pending_results.size() == 0) begin
        flag_mismatch("result transaction with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.hit_x !== want.hx) flag_mismatch("hit_x", out_ch.hit_x, want.hx);
        if (out_ch.hit_y !== want.hy) flag_mismatch("hit_y", out_ch.hit_y, want.hy);
        if (out_ch.cell_prob !== want.prob)
          flag_mismatch("cell_prob", out_ch.cell_prob, want.prob);
        if (out_ch.cell_visited !== want.vis)
          flag_mismatch("cell_visited", out_ch.cell_visited, want.vis);
        if (out_ch.bound_left !== want.b_left)
          flag_mismatch("bound_left", out_ch.bound_left, want.b_left);
        if (out_ch.bound_right !== want.b_right)
          flag_mismatch("bound_right", out_ch.bound_right, want.b_right);
        if (out_ch.bound_low !== want.b_low)
          flag_mismatch("bound_low", out_ch.bound_low, want.b_low);
        if (out_ch.bound_high !== want.b_high)
          flag_mismatch("bound_high", out_ch.bound_high, want.b_high);
      end
    end
  end

  // watchdog: cycles in a row without any transaction
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  task automatic test_reset_reads();
    send_read(8'd0, 8'd0);
    send_read(8'd255, 8'd255);
    send_read(8'd255, 8'd0);
    drain();
  endtask

  task automatic test_beam_extremes();
    send_beam(8'd128, 8'd128, 16'd0, 16'd0, 16'd0);          // zero range: robot cell only
    send_beam(8'd128, 8'd128, 16'd0, 16'd500, 16'd0);
    send_beam(8'd128, 8'd128, 16'd16384, 16'd500, 16'd0);
    send_beam(8'd128, 8'd128, 16'd32768, 16'd7999, 16'd0);   // just under threshold
    send_beam(8'd128, 8'd128, 16'd49152, 16'd8000, 16'd0);   // at threshold: miss
    send_beam(8'd0, 8'd0, 16'd65535, 16'd65535, 16'd1);      // wraps to angle 0
    send_beam(8'd255, 8'd255, 16'd40000, 16'd65535, 16'd0);  // clamps low
    send_beam(8'd0, 8'd255, 16'd8192, 16'd3000, 16'd12000);
    send_read(8'(last_hx), 8'(last_hy));
    send_read(8'd128, 8'd128);
    drain();
  endtask

  task automatic test_register_sweep();
    write_reg(REG_CELL_SIZE, 16'd0);  // zero cell size acts as one
    send_beam(8'd100, 8'd100, 16'd10000, 16'd40, 16'd0);
    drain();
    write_reg(REG_CELL_SIZE, 16'd65535);
    write_reg(REG_RANGE_THR, 16'd65535);
    write_reg(REG_HIT_RATE, 16'd65534);
    write_reg(REG_PRIOR, 16'd65534);  // grid keeps its old contents
    send_beam(8'd50, 8'd60, 16'd0, 16'd65535, 16'd0);
    send_read(8'd51, 8'd60);
    drain();
    write_reg(REG_CELL_SIZE, 16'd1);
    write_reg(REG_RANGE_THR, 16'd0);
    write_reg(REG_MISS_RATE, 16'd1);
    write_reg(REG_DECAY, 16'd0);
    write_reg(REG_PRIOR, 16'd1);
    send_beam(8'd200, 8'd30, 16'd20000, 16'd30, 16'd0);
    drain();
    write_reg(REG_CELL_SIZE, 16'd25);
    write_reg(REG_RANGE_THR, 16'd4000);
    write_reg(REG_HIT_RATE, 16'd1);
    write_reg(REG_MISS_RATE, 16'd65534);
    write_reg(REG_DECAY, 16'd65535);
    write_reg(REG_SPARE, 16'hFFFF);   // unknown index, ignored
    write_reg(REG_SPARE + 3'd1, 16'h1234);
    send_beam(8'd10, 8'd240, 16'd60000, 16'd1000, 16'd0);
    send_beam(8'd10, 8'd240, 16'd60000, 16'd5000, 16'd0);
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    for (int i = 0; i < 6; i++) send_read(8'($urandom), 8'($urandom));
    send_beam(8'd90, 8'd90, 16'($urandom), 16'd600, 16'($urandom));
    drain();
  endtask

  task automatic run_random(input int count);
    logic [15:0] rng;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3) && (i < count / 2);
      rng = ($urandom_range(99) < 80) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
      case ($urandom_range(9))
        0, 1: send_read(8'(last_hx), 8'(last_hy));
        2:    send_read(8'($urandom), 8'($urandom));
        default: send_beam(8'($urandom), 8'($urandom), 16'($urandom), rng, 16'($urandom));
      endcase
    end
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random_default();
    write_reg(REG_RANGE_THR, RANGE_THR_RST);
    write_reg(REG_CELL_SIZE, CELL_SIZE_RST);
    write_reg(REG_PRIOR, PRIOR_RST);
    write_reg(REG_HIT_RATE, HIT_RATE_RST);
    write_reg(REG_MISS_RATE, MISS_RATE_RST);
    write_reg(REG_DECAY, DECAY_RST);
    run_random(40);
  endtask

  task automatic test_random_mixed();
    write_reg(REG_RANGE_THR, 16'($urandom));
    write_reg(REG_CELL_SIZE, 16'($urandom_range(10, 200)));
    write_reg(REG_PRIOR, 16'($urandom_range(1, 65534)));
    write_reg(REG_HIT_RATE, 16'($urandom_range(1, 65534)));
    write_reg(REG_MISS_RATE, 16'($urandom_range(1, 65534)));
    write_reg(REG_DECAY, 16'($urandom));
    run_random(40);
  endtask

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.cmd <= CMD_BEAM;
    in_ch.pos_x <= '0;
    in_ch.pos_y <= '0;
    in_ch.heading <= '0;
    in_ch.beam_range <= '0;
    in_ch.beam_angle <= '0;
    in_ch.read_x <= '0;
    in_ch.read_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    regs[REG_RANGE_THR] = RANGE_THR_RST;
    regs[REG_CELL_SIZE] = CELL_SIZE_RST;
    regs[REG_PRIOR] = PRIOR_RST;
    regs[REG_HIT_RATE] = HIT_RATE_RST;
    regs[REG_MISS_RATE] = MISS_RATE_RST;
    regs[REG_DECAY] = DECAY_RST;
    for (int i = 0; i < GRID_W * GRID_H; i++) begin
      grid_prob[i] = PRIOR_RST;
      grid_seen[i] = 1'b0;
    end
    min_x = GRID_W - 1;
    max_x = 0;
    min_y = GRID_H - 1;
    max_y = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_reads();
    test_beam_extremes();
    test_register_sweep();
    test_backpressure();
    test_random_default();
    test_random_mixed();

    $display("Covered %0d beam and %0d read transactions, %0d results checked,",
             n_beams, n_reads, n_results);
    $display("register extremes, unknown index writes and a long output hold-off.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      if (pending_results.size() != 0)
        $display("%0d results never arrived", pending_results.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
